// ===== hdl/sws_pkg.sv =====
package sws_pkg;

   // request codes carried by req_type
   typedef enum logic [1:0] {
      REQ_RECORD    = 2'd0,
      REQ_QUERY     = 2'd1,
      REQ_CLEAR     = 2'd2,
      REQ_CLEAR_ALL = 2'd3
   } req_code_type;

   localparam int LAT_W   = 32;
   localparam int CAT_W   = 2;
   localparam int LIMIT_W = 11;
   localparam int COUNT_W = 11;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

   // percentile scale and points
   localparam logic [6:0] PCT_MED   = 7'd50;
   localparam logic [6:0] PCT_P90   = 7'd90;
   localparam logic [6:0] PCT_P99   = 7'd99;
   localparam logic [6:0] PCT_SCALE = 7'd100;

   // divide by the scale as multiply by ceil(2^PCT_SHIFT / scale), then shift
   localparam int PCT_SHIFT   = 32;
   localparam int PCT_RECIP_W = 26;
   localparam logic [PCT_RECIP_W-1:0] PCT_RECIP =
      PCT_RECIP_W'(((64'd1 << PCT_SHIFT) + 64'(PCT_SCALE) - 64'd1) / 64'(PCT_SCALE));

   // rank selectors: minimum, median, p90, p99, maximum
   localparam int NSEL    = 5;
   localparam int SEL_MIN = 0;
   localparam int SEL_MED = 1;
   localparam int SEL_P90 = 2;
   localparam int SEL_P99 = 3;
   localparam int SEL_MAX = 4;

   typedef struct packed {
      req_code_type       op;
      logic [CAT_W-1:0]   category;
      logic [LAT_W-1:0]   value;
   } cmd_type;

endpackage

// ===== hdl/sws_req_if.sv =====
interface sws_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [1:0]  category;
   logic [31:0] latency_value;

   modport source(output valid, req_type, category, latency_value, input ready);
   modport sink(input valid, req_type, category, latency_value, output ready);
endinterface

// ===== hdl/sws_rsp_if.sv =====
interface sws_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_category;
   logic [10:0] sample_count;
   logic        window_empty;
   logic [31:0] min_value;
   logic [31:0] max_value;
   logic [31:0] average_value;
   logic [31:0] median_value;
   logic [31:0] p90_value;
   logic [31:0] p99_value;

   modport source(output valid, result_category, sample_count, window_empty, min_value,
                  max_value, average_value, median_value, p90_value, p99_value,
                  input ready);
   modport sink(input valid, result_category, sample_count, window_empty, min_value,
                max_value, average_value, median_value, p90_value, p99_value,
                output ready);
endinterface

// ===== hdl/sws_ram.sv =====
module sws_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/sws_fifo.sv =====
module sws_fifo
   import sws_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_item,
   output logic    pop_valid,
   input  logic    pop,
   output cmd_type pop_item
);
   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] fill_ff;
   logic       do_push, do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end
endmodule

// ===== hdl/sws_front.sv =====
module sws_front
   import sws_pkg::*;
#(
   parameter int NUM_CATEGORIES = 4
) (
   input  logic      clock,
   input  logic      reset,
   sws_req_if.sink   req,
   output logic      push_valid,
   input  logic      push_ready,
   output cmd_type   push_item
);
   logic    hold_valid_ff, hold_valid_in;
   cmd_type hold_ff;
   logic    take, keep, push;

   assign req.ready = !hold_valid_ff || push_ready;
   assign take      = req.valid && req.ready;
   // drop requests for a category that does not exist, except clear all
   assign keep      = (req_code_type'(req.req_type) == REQ_CLEAR_ALL) ||
                      (5'(req.category) < 5'(NUM_CATEGORIES));
   assign push      = hold_valid_ff && push_ready;

   assign push_valid = hold_valid_ff;
   assign push_item  = hold_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (push) begin
         hold_valid_in = 1'b0;
      end
      if (take) begin
         hold_valid_in = keep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         hold_ff.op       <= req_code_type'(req.req_type);
         hold_ff.category <= req.category;
         hold_ff.value    <= req.latency_value;
      end
   end
endmodule

// ===== hdl/sws_div.sv =====
module sws_div #(
   parameter int WIDTH = 43
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient
);
   localparam int STEP_W = $clog2(WIDTH + 1);

   logic [WIDTH:0]      rem_ff;
   logic [WIDTH-1:0]    quo_ff, dsr_ff;
   logic [STEP_W-1:0]   step_ff;
   logic                done_ff;
   logic [WIDTH:0]      trial;
   logic                fits;

   assign trial    = {rem_ff[WIDTH-1:0], quo_ff[WIDTH-1]};
   assign fits     = trial >= {1'b0, dsr_ff};
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            step_ff <= STEP_W'(WIDTH);
         end else if (step_ff != '0) begin
            step_ff <= step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   // one quotient bit per cycle, restoring
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
      end else if (step_ff != '0) begin
         rem_ff <= fits ? (trial - {1'b0, dsr_ff}) : trial;
         quo_ff <= {quo_ff[WIDTH-2:0], fits};
      end
   end
endmodule

// ===== hdl/sws_engine.sv =====
module sws_engine
   import sws_pkg::*;
#(
   parameter int WINDOW_DEPTH   = 1024,
   parameter int NUM_CATEGORIES = 4,
   parameter int SAMPLE_WIDTH   = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [LIMIT_W-1:0] window_limit,
   input  logic               cmd_valid,
   output logic               cmd_pop,
   input  cmd_type            cmd_item,
   sws_rsp_if.source          rsp
);
   localparam int PW   = $clog2(WINDOW_DEPTH);
   localparam int CW   = $clog2(WINDOW_DEPTH + 1);
   localparam int CATW = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;
   localparam int AW   = $clog2(NUM_CATEGORIES * WINDOW_DEPTH);
   localparam int SW   = SAMPLE_WIDTH;
   localparam int SUMW = SW + CW;
   localparam int BW   = $clog2(SW);
   localparam int LW   = CW + LIMIT_W + 1;
   localparam int NPCT = 3;
   localparam int RPW  = CW + 7 + PCT_RECIP_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_REC_RD, ST_REC_WR, ST_AVG, ST_SWEEP, ST_DECIDE, ST_DONE
   } state_type;

   state_type         state_ff;
   logic [CW-1:0]     cnt_ff [NUM_CATEGORIES];
   logic [PW-1:0]     old_ff [NUM_CATEGORIES];
   logic [SUMW-1:0]   sum_ff [NUM_CATEGORIES];

   logic [CATW-1:0]   cat_ff;
   logic [CAT_W-1:0]  rcat_ff;
   logic [SW-1:0]     val_ff;
   logic [AW-1:0]     base_ff;
   logic [CW-1:0]     n_ff;
   logic [SUMW-1:0]   avg_ff;
   logic              empty_ff;
   logic [CW-1:0]     idx_ff;
   logic [PW-1:0]     rptr_ff;
   logic              rv_ff;
   logic [BW-1:0]     bit_ff;
   logic [SW-1:0]     mask_ff;
   logic [SW-1:0]     pfx_ff  [NSEL];
   logic [CW-1:0]     rank_ff [NSEL];
   logic [CW-1:0]     zc_ff   [NSEL];
   logic [CW+6:0]     rprod_ff [NPCT];

   logic              div_start_ff;
   logic [SUMW-1:0]   div_a_ff, div_b_ff;
   logic              div_done;
   logic [SUMW-1:0]   div_q;

   logic              rsp_valid_ff;
   logic [CAT_W-1:0]  o_cat_ff;
   logic [COUNT_W-1:0] o_cnt_ff;
   logic              o_empty_ff;
   logic [31:0]       o_min_ff, o_max_ff, o_avg_ff, o_med_ff, o_p90_ff, o_p99_ff;

   logic              mem_we;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [SW-1:0]     mem_rdata;

   logic [CATW-1:0]   cmd_cat;
   logic [SW+LAT_W-1:0] val_ext;
   logic [CW-1:0]     cur_cnt;
   logic [PW-1:0]     cur_old, old_next, slot;
   logic [CW:0]       slot_sum;
   logic              full, drop_old;
   logic [SW-1:0]     drop_val;
   logic              out_free;

   function automatic logic [6:0] pct_point(input int k);
      logic [6:0] p;
      case (k)
         0:       p = PCT_MED;
         1:       p = PCT_P90;
         default: p = PCT_P99;
      endcase
      return p;
   endfunction

   // floor(x / 100) by reciprocal multiply
   function automatic logic [CW-1:0] rank_of(input logic [CW+6:0] x);
      logic [RPW-1:0] p;
      p = RPW'(x) * RPW'(PCT_RECIP);
      return p[PCT_SHIFT +: CW];
   endfunction

   function automatic logic [31:0] to32(input logic [SUMW-1:0] v);
      logic [SUMW+31:0] e;
      e = {32'b0, v};
      return e[31:0];
   endfunction

   function automatic logic [COUNT_W-1:0] to_cnt(input logic [CW-1:0] v);
      logic [CW+COUNT_W-1:0] e;
      e = {{COUNT_W{1'b0}}, v};
      return e[COUNT_W-1:0];
   endfunction

   assign cmd_cat = CATW'(cmd_item.category);
   assign val_ext = {{SW{1'b0}}, cmd_item.value};
   assign cur_cnt = cnt_ff[cat_ff];
   assign cur_old = old_ff[cat_ff];
   assign old_next = (cur_old == PW'(WINDOW_DEPTH - 1)) ? '0 : cur_old + PW'(1);
   assign slot_sum = (CW+1)'(cur_old) + (CW+1)'(cur_cnt);
   assign slot = (slot_sum >= (CW+1)'(WINDOW_DEPTH)) ?
                 PW'(slot_sum - (CW+1)'(WINDOW_DEPTH)) : PW'(slot_sum);
   assign full = (cur_cnt == CW'(WINDOW_DEPTH));
   // a count above the limit sheds one sample; a limit above the depth acts as the depth
   assign drop_old = (LW'(cur_cnt) + LW'(1)) > LW'(window_limit);
   // with a limit of zero the sample just written is the one that leaves
   assign drop_val = (slot == cur_old) ? val_ff : mem_rdata;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign cmd_pop   = (state_ff == ST_IDLE) && cmd_valid;
   assign mem_we    = (state_ff == ST_REC_WR);
   assign mem_waddr = base_ff + AW'(slot);

   always_comb begin
      mem_raddr = base_ff + AW'(rptr_ff);
      if (state_ff == ST_REC_RD) begin
         mem_raddr = base_ff + AW'(cur_old);
      end
   end

   sws_ram #(.WIDTH(SW), .DEPTH(NUM_CATEGORIES * WINDOW_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (val_ff),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   sws_div #(.WIDTH(SUMW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_a_ff),
      .divisor  (div_b_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rv_ff        <= 1'b0;
         for (int c = 0; c < NUM_CATEGORIES; c++) begin
            cnt_ff[c] <= '0;
            old_ff[c] <= '0;
            sum_ff[c] <= '0;
         end
      end else begin
         div_start_ff <= 1'b0;
         if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  cat_ff  <= cmd_cat;
                  rcat_ff <= cmd_item.category;
                  val_ff  <= val_ext[SW-1:0];
                  base_ff <= AW'(cmd_cat) * AW'(WINDOW_DEPTH);
                  n_ff    <= cnt_ff[cmd_cat];
                  unique case (cmd_item.op)
                     REQ_RECORD: begin
                        state_ff <= ST_REC_RD;
                     end
                     REQ_QUERY: begin
                        if (cnt_ff[cmd_cat] == '0) begin
                           empty_ff <= 1'b1;
                           state_ff <= ST_DONE;
                        end else begin
                           empty_ff     <= 1'b0;
                           div_a_ff     <= sum_ff[cmd_cat];
                           div_b_ff     <= SUMW'(cnt_ff[cmd_cat]);
                           div_start_ff <= 1'b1;
                           state_ff     <= ST_AVG;
                        end
                     end
                     REQ_CLEAR: begin
                        cnt_ff[cmd_cat] <= '0;
                        old_ff[cmd_cat] <= '0;
                        sum_ff[cmd_cat] <= '0;
                     end
                     REQ_CLEAR_ALL: begin
                        for (int c = 0; c < NUM_CATEGORIES; c++) begin
                           cnt_ff[c] <= '0;
                           old_ff[c] <= '0;
                           sum_ff[c] <= '0;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_REC_RD: begin
               state_ff <= ST_REC_WR;
            end
            ST_REC_WR: begin
               // the sample is written at slot by the memory port
               if (full) begin
                  sum_ff[cat_ff] <= sum_ff[cat_ff] - SUMW'(mem_rdata) + SUMW'(val_ff);
                  old_ff[cat_ff] <= old_next;
               end else if (drop_old) begin
                  sum_ff[cat_ff] <= sum_ff[cat_ff] + SUMW'(val_ff) - SUMW'(drop_val);
                  old_ff[cat_ff] <= old_next;
               end else begin
                  sum_ff[cat_ff] <= sum_ff[cat_ff] + SUMW'(val_ff);
                  cnt_ff[cat_ff] <= cur_cnt + CW'(1);
               end
               state_ff <= ST_IDLE;
            end
            ST_AVG: begin
               // form the percentile ranks in two steps while the divider runs
               for (int k = 0; k < NPCT; k++) begin
                  rprod_ff[k]          <= (CW+7)'(n_ff - CW'(1)) * (CW+7)'(pct_point(k));
                  rank_ff[SEL_MED + k] <= rank_of(rprod_ff[k]);
               end
               if (div_done) begin
                  avg_ff           <= div_q;
                  rank_ff[SEL_MIN] <= '0;
                  rank_ff[SEL_MAX] <= n_ff - CW'(1);
                  for (int k = 0; k < NSEL; k++) begin
                     pfx_ff[k] <= '0;
                     zc_ff[k]  <= '0;
                  end
                  mask_ff  <= '0;
                  bit_ff   <= BW'(SW - 1);
                  idx_ff   <= '0;
                  rptr_ff  <= cur_old;
                  rv_ff    <= 1'b0;
                  state_ff <= ST_SWEEP;
               end
            end
            ST_SWEEP: begin
               if (idx_ff != n_ff) begin
                  rptr_ff <= (rptr_ff == PW'(WINDOW_DEPTH - 1)) ? '0 : rptr_ff + PW'(1);
                  idx_ff  <= idx_ff + CW'(1);
                  rv_ff   <= 1'b1;
               end else begin
                  rv_ff <= 1'b0;
                  if (!rv_ff) begin
                     state_ff <= ST_DECIDE;
                  end
               end
               if (rv_ff) begin
                  for (int k = 0; k < NSEL; k++) begin
                     if ((((mem_rdata ^ pfx_ff[k]) & mask_ff) == '0) && !mem_rdata[bit_ff]) begin
                        zc_ff[k] <= zc_ff[k] + CW'(1);
                     end
                  end
               end
            end
            ST_DECIDE: begin
               // settle one bit of each selected value, MSB first
               for (int k = 0; k < NSEL; k++) begin
                  if (rank_ff[k] >= zc_ff[k]) begin
                     pfx_ff[k][bit_ff] <= 1'b1;
                     rank_ff[k]        <= rank_ff[k] - zc_ff[k];
                  end
                  zc_ff[k] <= '0;
               end
               mask_ff[bit_ff] <= 1'b1;
               if (bit_ff == '0) begin
                  state_ff <= ST_DONE;
               end else begin
                  bit_ff   <= bit_ff - BW'(1);
                  idx_ff   <= '0;
                  rptr_ff  <= cur_old;
                  state_ff <= ST_SWEEP;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  o_cat_ff     <= rcat_ff;
                  o_empty_ff   <= empty_ff;
                  if (empty_ff) begin
                     o_cnt_ff <= '0;
                     o_min_ff <= '0;
                     o_max_ff <= '0;
                     o_avg_ff <= '0;
                     o_med_ff <= '0;
                     o_p90_ff <= '0;
                     o_p99_ff <= '0;
                  end else begin
                     o_cnt_ff <= to_cnt(n_ff);
                     o_min_ff <= to32(SUMW'(pfx_ff[SEL_MIN]));
                     o_max_ff <= to32(SUMW'(pfx_ff[SEL_MAX]));
                     o_avg_ff <= to32(avg_ff);
                     o_med_ff <= to32(SUMW'(pfx_ff[SEL_MED]));
                     o_p90_ff <= to32(SUMW'(pfx_ff[SEL_P90]));
                     o_p99_ff <= to32(SUMW'(pfx_ff[SEL_P99]));
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.result_category = o_cat_ff;
   assign rsp.sample_count    = o_cnt_ff;
   assign rsp.window_empty    = o_empty_ff;
   assign rsp.min_value       = o_min_ff;
   assign rsp.max_value       = o_max_ff;
   assign rsp.average_value   = o_avg_ff;
   assign rsp.median_value    = o_med_ff;
   assign rsp.p90_value       = o_p90_ff;
   assign rsp.p99_value       = o_p99_ff;
endmodule

// ===== hdl/sliding_window_latency_stats_top.sv =====
// Sliding-window latency statistics.
//
// req_ch takes one beat per request: record a sample, query a category,
// clear a category or clear all. Requests for a category at or above
// NUM_CATEGORIES are dropped on entry, except clear all. Only a query
// returns a beat on rsp_ch: count, empty flag, min, max, truncated average,
// median, p90 and p99 of the category's window.
// csr_wr_en/csr_wr_data write the window limit; write it only while idle.
//
// Flow: a request passes the front register and the queue before the back
// end takes it. There a record reads the oldest slot and then writes the
// new sample; a query of an empty window goes straight to its result. Any
// other query starts a serial average division (percentile ranks come
// from a reciprocal multiply meanwhile), makes SAMPLE_WIDTH passes over
// the window that settle one result bit each over the single read port,
// and then loads the result. One request at a time in the back end.
//
// Reset clears all counts, pointers and sums and sets the limit to 1024;
// the sample memory is not cleared, as only held slots are read. A stalled
// rsp_ch holds its beat; the back end keeps serving records and clears
// until the next query is ready to answer, then three more requests queue
// in the front register and queue before req_ch stalls.
module sliding_window_latency_stats_top
   import sws_pkg::*;
#(
   parameter int WINDOW_DEPTH   = 1024,
   parameter int NUM_CATEGORIES = 4,
   parameter int SAMPLE_WIDTH   = 32
) (
   input  logic               clock,
   input  logic               reset,
   sws_req_if.sink            req_ch,
   sws_rsp_if.source          rsp_ch,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data
);
   logic [LIMIT_W-1:0] window_limit_ff;
   logic    push_valid, push_ready;
   cmd_type push_item;
   logic    cmd_valid, cmd_pop;
   cmd_type cmd_item;

   // hold the window limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         window_limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         window_limit_ff <= csr_wr_data;
      end
   end

   // front end: accept and classify each request beat
   sws_front #(.NUM_CATEGORIES(NUM_CATEGORIES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // decouple front and back
   sws_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (cmd_valid),
      .pop        (cmd_pop),
      .pop_item   (cmd_item)
   );

   // back end: window store, running sums and rank selection
   sws_engine #(
      .WINDOW_DEPTH   (WINDOW_DEPTH),
      .NUM_CATEGORIES (NUM_CATEGORIES),
      .SAMPLE_WIDTH   (SAMPLE_WIDTH)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .window_limit (window_limit_ff),
      .cmd_valid    (cmd_valid),
      .cmd_pop      (cmd_pop),
      .cmd_item     (cmd_item),
      .rsp          (rsp_ch)
   );
endmodule

// ===== bench/sliding_window_latency_stats_top_test.sv =====
module sliding_window_latency_stats_top_test;
   import sws_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_DEPTH = 1024;
   localparam int NUM_CAT    = 4;
   // Extra cycles allowed for records to retire after their beats.
   localparam int SETTLE_CYCLES = 24;

   typedef bit [LAT_W-1:0] lat_list_type[$];

   // One expected answer to a query.
   typedef struct {
      bit [CAT_W-1:0]   category;
      bit [COUNT_W-1:0] count;
      bit               empty;
      bit [LAT_W-1:0]   min_v;
      bit [LAT_W-1:0]   max_v;
      bit [LAT_W-1:0]   avg_v;
      bit [LAT_W-1:0]   med_v;
      bit [LAT_W-1:0]   p90_v;
      bit [LAT_W-1:0]   p99_v;
   } window_stats_type;

   logic clock;
   logic reset = 1'b1;
   logic csr_wr_en;
   logic [LIMIT_W-1:0] csr_wr_data;

   sws_req_if req_ch ();
   sws_rsp_if rsp_ch ();

   sliding_window_latency_stats_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Mirror of the block: each category's window, oldest sample first.
   lat_list_type     windows[NUM_CAT];
   int unsigned      limit_mirror = LIMIT_RESET;
   cmd_type          pending_cmds[$];
   window_stats_type expected_stats[$];
   int               fail_count = 0;
   int               beats_sent = 0;
   int               stats_checked = 0;

   // Clock plus known levels on every input before the first edge.
   initial begin
      clock = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.req_type = '0;
      req_ch.category = '0;
      req_ch.latency_value = '0;
      rsp_ch.ready = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // Generous ceiling: the whole run needs well under a millisecond.
   initial begin
      #100ms;
      $display("CHECK FAILED");
      $finish;
   end

   // Work out the statistics a query of category c should return.
   function automatic window_stats_type window_stats(bit [CAT_W-1:0] c);
      window_stats_type s;
      lat_list_type     sorted;
      longint unsigned  total;
      int unsigned      n;
      s = '{default: '0};
      s.category = c;
      sorted = windows[c];
      n = sorted.size();
      if (n == 0) begin
         s.empty = 1'b1;
         return s;
      end
      total = 0;
      foreach (sorted[i]) total += sorted[i];
      sorted.sort();
      s.count = COUNT_W'(n);
      s.min_v = sorted[0];
      s.max_v = sorted[n-1];
      s.avg_v = LAT_W'(total / n);
      s.med_v = sorted[(n-1) * 50 / 100];
      s.p90_v = sorted[(n-1) * 90 / 100];
      s.p99_v = sorted[(n-1) * 99 / 100];
      return s;
   endfunction

   // Advance the mirror by one accepted request beat.
   function automatic void apply_request(cmd_type cmd);
      int unsigned cap;
      cap = (limit_mirror > RING_DEPTH) ? RING_DEPTH : limit_mirror;
      case (cmd.op)
         REQ_RECORD: begin
            windows[cmd.category] = {windows[cmd.category], cmd.value};
            // Only one sample drops per record, even after the limit was lowered.
            if (windows[cmd.category].size() > cap)
               void'(windows[cmd.category].pop_front());
         end
         REQ_QUERY: expected_stats = {expected_stats, window_stats(cmd.category)};
         REQ_CLEAR: windows[cmd.category].delete();
         REQ_CLEAR_ALL: begin
            foreach (windows[i]) windows[i].delete();
         end
      endcase
   endfunction

   // Sender: bursts of random length separated by random gaps.
   int burst_left = 1;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            apply_request(cmd_type'({req_ch.req_type, req_ch.category,
                                     req_ch.latency_value}));
            beats_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               cmd_type nxt;
               nxt = pending_cmds.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.req_type <= nxt.op;
               req_ch.category <= nxt.category;
               req_ch.latency_value <= nxt.value;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 12);
                  // Hold back-to-back about a third of the time.
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: pattern_tick switches the stall probability between three levels, including no stalls.
   int ready_pct = 100;
   int pattern_tick = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         pattern_tick++;
         if (pattern_tick % 50 == 0) begin
            case ($urandom_range(0, 2))
               0: ready_pct = 100;
               1: ready_pct = 60;
               default: ready_pct = 20;
            endcase
         end
         rsp_ch.ready <= ($urandom_range(0, 99) < ready_pct);
      end
   end

   function automatic void check_field(string name, longint unsigned exp_v,
                                       longint unsigned act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   // Monitor: compare every result beat with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_stats.size() == 0) begin
            $error("result beat with no query outstanding");
            fail_count++;
         end else begin
            window_stats_type s;
            s = expected_stats.pop_front();
            check_field("result_category", s.category, rsp_ch.result_category);
            check_field("sample_count", s.count, rsp_ch.sample_count);
            check_field("window_empty", s.empty, rsp_ch.window_empty);
            check_field("min_value", s.min_v, rsp_ch.min_value);
            check_field("max_value", s.max_v, rsp_ch.max_value);
            check_field("average_value", s.avg_v, rsp_ch.average_value);
            check_field("median_value", s.med_v, rsp_ch.median_value);
            check_field("p90_value", s.p90_v, rsp_ch.p90_value);
            check_field("p99_value", s.p99_v, rsp_ch.p99_value);
            stats_checked++;
         end
      end
   end

   task automatic queue_cmd(req_code_type op, int c, bit [LAT_W-1:0] v);
      cmd_type cmd;
      cmd.op = op;
      cmd.category = CAT_W'(c);
      cmd.value = v;
      pending_cmds = {pending_cmds, cmd};
   endtask

   // Drain everything, then let trailing records retire.
   task automatic wait_idle();
      while (pending_cmds.size() > 0 || req_ch.valid || expected_stats.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(int unsigned v);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= LIMIT_W'(v);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_mirror = v;
      @(posedge clock);
   endtask

   function automatic bit [LAT_W-1:0] rand_latency();
      case ($urandom_range(0, 5))
         0: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         1: return $urandom_range(0, 3);
         2: return $urandom_range(0, 5000);
         default: return $urandom();
      endcase
   endfunction

   // Mostly records with regular queries; clears now and then to restart windows.
   task automatic random_phase(int n_items);
      int roll;
      repeat (n_items) begin
         roll = $urandom_range(0, 99);
         if (roll < 55)      queue_cmd(REQ_RECORD, $urandom_range(0, 3), rand_latency());
         else if (roll < 85) queue_cmd(REQ_QUERY, $urandom_range(0, 3), $urandom());
         else if (roll < 96) queue_cmd(REQ_CLEAR, $urandom_range(0, 3), $urandom());
         else                queue_cmd(REQ_CLEAR_ALL, $urandom_range(0, 3), $urandom());
      end
   endtask

   initial begin
      int phase_limits[6] = '{7, 1, 33, 1024, 2047, 64};
      @(negedge reset);

      // Directed: empty window, extremes, every request kind, clears.
      queue_cmd(REQ_QUERY, 0, 32'd0);
      queue_cmd(REQ_RECORD, 0, 32'd0);
      queue_cmd(REQ_RECORD, 0, 32'hFFFF_FFFF);
      queue_cmd(REQ_RECORD, 0, 32'd1);
      queue_cmd(REQ_RECORD, 0, 32'hFFFF_FFFE);
      queue_cmd(REQ_QUERY, 0, 32'd0);
      queue_cmd(REQ_RECORD, 1, 32'hAAAA_AAAA);
      queue_cmd(REQ_RECORD, 1, 32'h5555_5555);
      queue_cmd(REQ_QUERY, 1, 32'hFFFF_FFFF);
      queue_cmd(REQ_CLEAR, 0, 32'd0);
      queue_cmd(REQ_QUERY, 0, 32'd0);
      queue_cmd(REQ_RECORD, 2, 32'd12345);
      queue_cmd(REQ_RECORD, 3, 32'h8000_0000);
      queue_cmd(REQ_CLEAR_ALL, 3, 32'd0);
      queue_cmd(REQ_QUERY, 1, 32'd0);
      queue_cmd(REQ_QUERY, 2, 32'd0);
      queue_cmd(REQ_RECORD, 3, 32'h7FFF_FFFF);
      queue_cmd(REQ_RECORD, 3, 32'h0000_0003);
      queue_cmd(REQ_QUERY, 3, 32'd0);

      // Limit of zero: every record drops its own sample.
      write_limit(0);
      queue_cmd(REQ_RECORD, 2, 32'd99);
      queue_cmd(REQ_QUERY, 2, 32'd0);

      // Lowered limit: count stays above it, as each record drops only one sample.
      write_limit(LIMIT_RESET);
      queue_cmd(REQ_CLEAR_ALL, 0, 32'd0);
      repeat (6) queue_cmd(REQ_RECORD, 1, rand_latency());
      write_limit(3);
      queue_cmd(REQ_RECORD, 1, 32'd42);
      queue_cmd(REQ_QUERY, 1, 32'd0);

      foreach (phase_limits[i]) begin
         write_limit(phase_limits[i]);
         random_phase(42);
      end

      // Close with a query of every category.
      for (int c = 0; c < NUM_CAT; c++) queue_cmd(REQ_QUERY, c, 32'd0);

      wait_idle();
      repeat (50) @(posedge clock);

      $display("Sent %0d request beats over limits 0..2047, checked %0d query results.",
               beats_sent, stats_checked);
      if (fail_count == 0 && expected_stats.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
